@@ src/impulse_collision_response_assert.svh @@
// Assertion macros for the top-level RTL file of the collision response block.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef IMPULSE_COLLISION_RESPONSE_ASSERT_SVH
`define IMPULSE_COLLISION_RESPONSE_ASSERT_SVH
`ifndef SYNTHESIS
`define ICR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("collision response assertion failed");
`define ICR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collision response assertion failed");
`else
`define ICR_ASSERT(lbl, prop)
`define ICR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/icr_pkg.sv @@
package icr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Outcome codes.
  localparam logic [2:0] OUT_TWO_BODY    = 3'd0;
  localparam logic [2:0] OUT_STATIC      = 3'd1;
  localparam logic [2:0] OUT_BOTH_STATIC = 3'd2;
  localparam logic [2:0] OUT_SEPARATING  = 3'd3;
  localparam logic [2:0] OUT_ZERO_MASS   = 3'd4;

  // Static mask codes.
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_A    = 2'd1;
  localparam logic [1:0] ST_B    = 2'd2;
  localparam logic [1:0] ST_BOTH = 2'd3;

  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic [16:0]        bounce_a;
    logic [16:0]        bounce_b;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
    logic [1:0]         static_mask;
    logic [1:0]         knock_mask;
  } icr_item_t;

endpackage

@@ src/icr_contact_if.sv @@
interface icr_contact_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic [16:0]        bounce_a;
  logic [16:0]        bounce_b;
  logic [30:0]        inv_mass_a;
  logic [30:0]        inv_mass_b;
  logic [1:0]         static_mask;
  logic [1:0]         knock_mask;

  modport source (
    output valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
           bounce_a, bounce_b, inv_mass_a, inv_mass_b, static_mask, knock_mask,
    input  ready
  );
  modport sink (
    input  valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
           bounce_a, bounce_b, inv_mass_a, inv_mass_b, static_mask, knock_mask,
    output ready
  );
endinterface

@@ src/icr_result_if.sv @@
interface icr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_a_x;
  logic signed [31:0] new_vel_a_y;
  logic signed [31:0] new_vel_b_x;
  logic signed [31:0] new_vel_b_y;
  logic [1:0]         fall_mask;
  logic [2:0]         outcome;

  modport source (
    output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
           fall_mask, outcome,
    input  ready
  );
  modport sink (
    input  valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
           fall_mask, outcome,
    output ready
  );
endinterface

@@ src/impulse_collision_response.sv @@
// Impulse collision response for one 2D contact per request.
// The contact channel carries both velocities, the contact normal, bounciness,
// inverse masses and the static and knockable masks; the result channel
// returns the new velocities, the fall mask and an outcome code. Both use
// valid/ready, and a request moves on a clock edge where both are high.
// The pipeline (Q16.16 when FRAC_BITS is 16) has one input register, one
// divider stage per quotient bit (FRAC_BITS + 1) for the mass ratios, and
// five arithmetic stages, each at most one multiplier deep, the last of
// which is the output register. A new contact is taken every cycle while no result is stalled.
// The whole pipeline advances together: when the receiver holds ready low
// while a result is waiting, every stage holds and contact.ready drops, so
// nothing is lost or repeated. Synchronous reset clears all valid bits and
// the block is ready in the cycle after reset falls.
module impulse_collision_response #(
  parameter int FRAC_BITS = icr_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  icr_contact_if.sink  contact,
  icr_result_if.source result
);

  localparam int XW    = 80;
  localparam int PXW   = 51;
  localparam int DOTW  = 52;
  localparam int DW    = 53 - FRAC_BITS;
  localparam int OPEW  = FRAC_BITS + 2;
  localparam int PRW   = DW + OPEW + 1;
  localparam int SW    = 54 - FRAC_BITS;
  localparam int NW    = 55 - FRAC_BITS;
  localparam int PAW   = NW + FRAC_BITS + 2;
  localparam int SAW   = 55 - FRAC_BITS;
  localparam int QPW   = SAW + 18;
  localparam int QW    = 72 - 2 * FRAC_BITS;
  localparam int RW    = ((QW > 33) ? QW : 33) + 1;
  localparam int BW    = (OPEW > 17) ? OPEW : 17;

  localparam logic signed [XW-1:0] HALF    = XW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [XW-1:0] HALF_M1 = HALF - XW'(64'd1);
  localparam logic [BW-1:0]        ONE_B   = BW'(64'd1 << FRAC_BITS);
  localparam logic [OPEW-1:0]      ONE_E   = OPEW'(64'd1 << FRAC_BITS);
  localparam logic signed [RW-1:0] VMAX    = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] VMIN    = RW'(-64'sd2147483648);

  // Divide by 2^F, rounding to nearest with ties away from zero.
  function automatic logic signed [XW-1:0] rsh(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] t;
    t = x + (x[XW-1] ? HALF_M1 : HALF);
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] sat(input logic signed [RW-1:0] v);
    logic [31:0] r;
    if (v > VMAX) begin
      r = VMAX[31:0];
    end else if (v < VMIN) begin
      r = VMIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic adv;
  assign adv           = !result.valid || result.ready;
  assign contact.ready = adv;

  // Input register.
  logic               in_valid;
  icr_pkg::icr_item_t in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= contact.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item.vel_a_x     <= contact.vel_a_x;
      in_item.vel_a_y     <= contact.vel_a_y;
      in_item.vel_b_x     <= contact.vel_b_x;
      in_item.vel_b_y     <= contact.vel_b_y;
      in_item.normal_x    <= contact.normal_x;
      in_item.normal_y    <= contact.normal_y;
      in_item.bounce_a    <= contact.bounce_a;
      in_item.bounce_b    <= contact.bounce_b;
      in_item.inv_mass_a  <= contact.inv_mass_a;
      in_item.inv_mass_b  <= contact.inv_mass_b;
      in_item.static_mask <= contact.static_mask;
      in_item.knock_mask  <= contact.knock_mask;
    end
  end

  logic               dv_valid;
  icr_pkg::icr_item_t dv_item;
  logic [FRAC_BITS:0] dv_ra;
  logic [FRAC_BITS:0] dv_rb;

  icr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (dv_valid),
    .out_item  (dv_item),
    .ra        (dv_ra),
    .rb        (dv_rb)
  );

  // Stage 1: pick the velocity to project, restitution, normal products.
  logic signed [32:0]  ux;
  logic signed [32:0]  uy;
  logic [BW-1:0]       ba_w;
  logic [BW-1:0]       bb_w;
  logic [BW-1:0]       e_w;

  always_comb begin
    ba_w = BW'(dv_item.bounce_a);
    bb_w = BW'(dv_item.bounce_b);
    if (ba_w > ONE_B) begin
      ba_w = ONE_B;
    end
    if (bb_w > ONE_B) begin
      bb_w = ONE_B;
    end
    e_w = (ba_w < bb_w) ? ba_w : bb_w;
    if (dv_item.static_mask == icr_pkg::ST_A) begin
      e_w = bb_w;
    end
    case (dv_item.static_mask)
      icr_pkg::ST_NONE: begin
        ux = 33'(dv_item.vel_b_x) - 33'(dv_item.vel_a_x);
        uy = 33'(dv_item.vel_b_y) - 33'(dv_item.vel_a_y);
      end
      icr_pkg::ST_B: begin
        ux = 33'(dv_item.vel_a_x);
        uy = 33'(dv_item.vel_a_y);
      end
      default: begin
        ux = 33'(dv_item.vel_b_x);
        uy = 33'(dv_item.vel_b_y);
      end
    endcase
  end

  logic                  e1_valid;
  icr_pkg::icr_item_t    e1_item;
  logic [FRAC_BITS:0]    e1_ra;
  logic [FRAC_BITS:0]    e1_rb;
  logic signed [PXW-1:0] e1_px;
  logic signed [PXW-1:0] e1_py;
  logic [OPEW-1:0]       e1_ope;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_item <= dv_item;
      e1_ra   <= dv_ra;
      e1_rb   <= dv_rb;
      e1_px   <= ux * dv_item.normal_x;
      e1_py   <= uy * dv_item.normal_y;
      e1_ope  <= ONE_E + OPEW'(e_w);
    end
  end

  // Stage 2: dot product, separation test, scale by one plus restitution.
  logic signed [DOTW-1:0] dot;
  logic signed [XW-1:0]   d_full;
  logic signed [DW-1:0]   d;
  logic [2:0]             oc;
  logic [1:0]             fall;

  assign dot    = DOTW'(e1_px) + DOTW'(e1_py);
  assign d_full = rsh(XW'(dot));
  assign d      = d_full[DW-1:0];

  always_comb begin
    case (e1_item.static_mask)
      icr_pkg::ST_BOTH: begin
        oc   = icr_pkg::OUT_BOTH_STATIC;
        fall = 2'b00;
      end
      icr_pkg::ST_A: begin
        oc   = icr_pkg::OUT_STATIC;
        fall = e1_item.knock_mask & 2'b10;
      end
      icr_pkg::ST_B: begin
        oc   = icr_pkg::OUT_STATIC;
        fall = e1_item.knock_mask & 2'b01;
      end
      default: begin
        fall = e1_item.knock_mask;
        if (dot > 0) begin
          oc = icr_pkg::OUT_SEPARATING;
        end else if (e1_item.inv_mass_a == '0 && e1_item.inv_mass_b == '0) begin
          oc = icr_pkg::OUT_ZERO_MASS;
        end else begin
          oc = icr_pkg::OUT_TWO_BODY;
        end
      end
    endcase
  end

  logic                  e2_valid;
  icr_pkg::icr_item_t    e2_item;
  logic [FRAC_BITS:0]    e2_ra;
  logic [FRAC_BITS:0]    e2_rb;
  logic signed [PRW-1:0] e2_prod;
  logic [2:0]            e2_outcome;
  logic [1:0]            e2_fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (adv) begin
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_item    <= e1_item;
      e2_ra      <= e1_ra;
      e2_rb      <= e1_rb;
      e2_prod    <= d * $signed({1'b0, e1_ope});
      e2_outcome <= oc;
      e2_fall    <= fall;
    end
  end

  // Stage 3: rounded impulse magnitude and its split over the two masses.
  logic signed [XW-1:0] s_full;
  logic signed [SW-1:0] s;
  logic signed [NW-1:0] ns;

  assign s_full = rsh(XW'(e2_prod));
  assign s      = s_full[SW-1:0];
  assign ns     = -NW'(s);

  logic                  e3_valid;
  icr_pkg::icr_item_t    e3_item;
  logic [2:0]            e3_outcome;
  logic [1:0]            e3_fall;
  logic signed [SW-1:0]  e3_s;
  logic signed [PAW-1:0] e3_pa;
  logic signed [PAW-1:0] e3_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_valid <= 1'b0;
    end else if (adv) begin
      e3_valid <= e2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_item    <= e2_item;
      e3_outcome <= e2_outcome;
      e3_fall    <= e2_fall;
      e3_s       <= s;
      e3_pa      <= ns * $signed({1'b0, e2_ra});
      e3_pb      <= ns * $signed({1'b0, e2_rb});
    end
  end

  // Stage 4: per-body impulse along the normal. A single moving body takes the
  // full reflection with a sign that matches the two-body update form.
  logic signed [XW-1:0]  pa_full;
  logic signed [XW-1:0]  pb_full;
  logic signed [SAW-1:0] sa;
  logic signed [SAW-1:0] sb;
  logic                  is_static;

  assign pa_full   = rsh(XW'(e3_pa));
  assign pb_full   = rsh(XW'(e3_pb));
  assign is_static = e3_outcome == icr_pkg::OUT_STATIC;
  assign sa        = is_static ? SAW'(e3_s) : pa_full[SAW-1:0];
  assign sb        = is_static ? -SAW'(e3_s) : pb_full[SAW-1:0];

  logic                  e4_valid;
  icr_pkg::icr_item_t    e4_item;
  logic [2:0]            e4_outcome;
  logic [1:0]            e4_fall;
  logic signed [QPW-1:0] e4_qax;
  logic signed [QPW-1:0] e4_qay;
  logic signed [QPW-1:0] e4_qbx;
  logic signed [QPW-1:0] e4_qby;

  always_ff @(posedge clk) begin
    if (rst) begin
      e4_valid <= 1'b0;
    end else if (adv) begin
      e4_valid <= e3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_item    <= e3_item;
      e4_outcome <= e3_outcome;
      e4_fall    <= e3_fall;
      e4_qax     <= sa * e3_item.normal_x;
      e4_qay     <= sa * e3_item.normal_y;
      e4_qbx     <= sb * e3_item.normal_x;
      e4_qby     <= sb * e3_item.normal_y;
    end
  end

  // Stage 5: apply the velocity change, saturate, output register.
  logic signed [XW-1:0] fax_full;
  logic signed [XW-1:0] fay_full;
  logic signed [XW-1:0] fbx_full;
  logic signed [XW-1:0] fby_full;
  logic signed [RW-1:0] rax;
  logic signed [RW-1:0] ray;
  logic signed [RW-1:0] rbx;
  logic signed [RW-1:0] rby;
  logic                 upd_a;
  logic                 upd_b;

  assign fax_full = rsh(XW'(e4_qax));
  assign fay_full = rsh(XW'(e4_qay));
  assign fbx_full = rsh(XW'(e4_qbx));
  assign fby_full = rsh(XW'(e4_qby));

  assign upd_a = (e4_outcome == icr_pkg::OUT_TWO_BODY) ||
                 (e4_outcome == icr_pkg::OUT_STATIC &&
                  e4_item.static_mask == icr_pkg::ST_B);
  assign upd_b = (e4_outcome == icr_pkg::OUT_TWO_BODY) ||
                 (e4_outcome == icr_pkg::OUT_STATIC &&
                  e4_item.static_mask == icr_pkg::ST_A);

  assign rax = upd_a ? RW'(e4_item.vel_a_x) - RW'($signed(fax_full[QW-1:0]))
                     : RW'(e4_item.vel_a_x);
  assign ray = upd_a ? RW'(e4_item.vel_a_y) - RW'($signed(fay_full[QW-1:0]))
                     : RW'(e4_item.vel_a_y);
  assign rbx = upd_b ? RW'(e4_item.vel_b_x) + RW'($signed(fbx_full[QW-1:0]))
                     : RW'(e4_item.vel_b_x);
  assign rby = upd_b ? RW'(e4_item.vel_b_y) + RW'($signed(fby_full[QW-1:0]))
                     : RW'(e4_item.vel_b_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= e4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.new_vel_a_x <= sat(rax);
      result.new_vel_a_y <= sat(ray);
      result.new_vel_b_x <= sat(rbx);
      result.new_vel_b_y <= sat(rby);
      result.fall_mask   <= e4_fall;
      result.outcome     <= e4_outcome;
    end
  end

  logic res_both_static;
  logic res_static;
  logic res_stalled;

  assign res_both_static = result.valid && result.outcome == icr_pkg::OUT_BOTH_STATIC;
  assign res_static      = result.valid && result.outcome == icr_pkg::OUT_STATIC;
  assign res_stalled     = result.valid && !result.ready;

`include "impulse_collision_response_assert.svh"

  `ICR_ASSERT(a_both_static_no_fall, res_both_static |-> result.fall_mask == 2'b00)
  `ICR_ASSERT(a_static_one_fall, res_static |-> $onehot0(result.fall_mask))
  `ICR_ASSERT_NEXT(a_stall_keeps_result, res_stalled, result.valid)
  `ICR_ASSERT(a_ready_when_empty, !result.valid |-> contact.ready)

endmodule

@@ src/icr_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, both mass ratios
// round(m * 2^F / (ma + mb)) side by side. The contact rides along with it.
module icr_div #(
  parameter int FRAC_BITS = icr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  icr_pkg::icr_item_t    in_item,
  output logic                  out_valid,
  output icr_pkg::icr_item_t    out_item,
  output logic [FRAC_BITS:0]    ra,
  output logic [FRAC_BITS:0]    rb
);

  localparam int STAGES = FRAC_BITS + 1;
  localparam int NUMW   = 32 + FRAC_BITS;

  logic [31:0]     msum;
  logic [NUMW-1:0] num_a;
  logic [NUMW-1:0] num_b;

  assign msum  = 32'(in_item.inv_mass_a) + 32'(in_item.inv_mass_b);
  // Adding half the divisor turns the truncating quotient into a rounded one.
  assign num_a = {1'b0, in_item.inv_mass_a, FRAC_BITS'(0)} + NUMW'(msum[31:1]);
  assign num_b = {1'b0, in_item.inv_mass_b, FRAC_BITS'(0)} + NUMW'(msum[31:1]);

  logic               valid_q [STAGES];
  icr_pkg::icr_item_t item_q  [STAGES];
  logic [FRAC_BITS:0] lq_a_q  [STAGES];
  logic [FRAC_BITS:0] lq_b_q  [STAGES];
  logic [31:0]        rem_a_q [STAGES-1];
  logic [31:0]        rem_b_q [STAGES-1];
  logic [31:0]        div_q   [STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic               v;
    icr_pkg::icr_item_t it;
    logic [31:0]        rem_a;
    logic [31:0]        rem_b;
    logic [31:0]        dv;
    logic [FRAC_BITS:0] lqa;
    logic [FRAC_BITS:0] lqb;
    logic [32:0]        trial_a;
    logic [32:0]        trial_b;
    logic               ge_a;
    logic               ge_b;

    if (k == 0) begin : g_first
      assign v     = in_valid;
      assign it    = in_item;
      assign rem_a = {1'b0, num_a[NUMW-1:FRAC_BITS+1]};
      assign rem_b = {1'b0, num_b[NUMW-1:FRAC_BITS+1]};
      assign dv    = msum;
      assign lqa   = num_a[FRAC_BITS:0];
      assign lqb   = num_b[FRAC_BITS:0];
    end else begin : g_next
      assign v     = valid_q[k-1];
      assign it    = item_q[k-1];
      assign rem_a = rem_a_q[k-1];
      assign rem_b = rem_b_q[k-1];
      assign dv    = div_q[k-1];
      assign lqa   = lq_a_q[k-1];
      assign lqb   = lq_b_q[k-1];
    end

    assign trial_a = {rem_a, lqa[FRAC_BITS]};
    assign trial_b = {rem_b, lqb[FRAC_BITS]};
    assign ge_a    = trial_a >= {1'b0, dv};
    assign ge_b    = trial_b >= {1'b0, dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= v;
      end
    end

    // Numerator bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (adv) begin
        item_q[k] <= it;
        lq_a_q[k] <= {lqa[FRAC_BITS-1:0], ge_a};
        lq_b_q[k] <= {lqb[FRAC_BITS-1:0], ge_b};
      end
    end

    if (k < STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_a_q[k] <= ge_a ? trial_a[31:0] - dv : trial_a[31:0];
          rem_b_q[k] <= ge_b ? trial_b[31:0] - dv : trial_b[31:0];
          div_q[k]   <= dv;
        end
      end
    end
  end

  assign out_valid = valid_q[STAGES-1];
  assign out_item  = item_q[STAGES-1];
  assign ra        = lq_a_q[STAGES-1];
  assign rb        = lq_b_q[STAGES-1];

endmodule
